// File: sv/jogwheel_and_flux_button_qualifier_assert.svh
// Assertion macros used by the checker file.
`ifndef JOGWHEEL_AND_FLUX_BUTTON_QUALIFIER_ASSERT_SVH
`define JOGWHEEL_AND_FLUX_BUTTON_QUALIFIER_ASSERT_SVH

// Property checked outside reset.
`define JFBQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("jfbq assertion failed");

// Property checked at every edge, reset included.
`define JFBQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("jfbq assertion failed");

`endif

// File: sv/jfbq_pkg.sv
package jfbq_pkg;

  localparam int CountW  = 16;
  localparam int FluxW   = 12;
  localparam int HoldW   = 16;
  localparam int ThreshW = 12;
  localparam int InDataW = 32;
  localparam int OutDataW = 8;
  localparam int AddrW   = 4;

  localparam logic [HoldW-1:0]   HoldGameReset  = 16'd150;
  localparam logic [HoldW-1:0]   HoldMenuReset  = 16'd1;
  localparam logic [ThreshW-1:0] ThresholdReset = 12'd10;

  localparam logic [1:0] RegHoldGame  = 2'd0;
  localparam logic [1:0] RegHoldMenu  = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;

  typedef struct packed {
    logic [HoldW-1:0]   hold_ticks_game;
    logic [HoldW-1:0]   hold_ticks_menu;
    logic [ThreshW-1:0] press_threshold;
  } cfg_t;

  typedef struct packed {
    logic pressed_down;
    logic turned_right;
    logic turned_left;
  } result_t;

endpackage

// File: sv/jfbq_cfg.sv
module jfbq_cfg
  import jfbq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks_game <= HoldGameReset;
      cfg.hold_ticks_menu <= HoldMenuReset;
      cfg.press_threshold <= ThresholdReset;
    end else if (wr_en) begin
      unique case (reg_index)
        RegHoldGame:  cfg.hold_ticks_game <= pwdata[HoldW-1:0];
        RegHoldMenu:  cfg.hold_ticks_menu <= pwdata[HoldW-1:0];
        RegThreshold: cfg.press_threshold <= pwdata[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      RegHoldGame:  prdata = {16'd0, cfg.hold_ticks_game};
      RegHoldMenu:  prdata = {16'd0, cfg.hold_ticks_menu};
      RegThreshold: prdata = {20'd0, cfg.press_threshold};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// File: sv/jfbq_core.sv
module jfbq_core
  import jfbq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic [CountW-1:0] encoder_count,
  input  logic [FluxW-1:0]  flux_z,
  input  logic              menu_active,
  output result_t           result
);

  logic [CountW-1:0]  last_count;
  logic [HoldW-1:0]   left_hold;
  logic [HoldW-1:0]   right_hold;
  logic [FluxW-1:0]   flux_reference;
  logic               reference_taken;

  logic [CountW-1:0]  last_count_next;
  logic [HoldW-1:0]   left_hold_next;
  logic [HoldW-1:0]   right_hold_next;
  logic [FluxW-1:0]   flux_reference_next;
  logic [CountW-1:0]  diff;
  logic [HoldW-1:0]   period;
  logic [HoldW-1:0]   left_dec;
  logic [HoldW-1:0]   right_dec;
  logic signed [FluxW:0] delta;
  logic [FluxW:0]     delta_abs;

  assign diff      = encoder_count - last_count;
  assign period    = menu_active ? cfg.hold_ticks_menu : cfg.hold_ticks_game;
  assign left_dec  = (left_hold != '0) ? left_hold - 1'b1 : '0;
  assign right_dec = (right_hold != '0) ? right_hold - 1'b1 : '0;

  always_comb begin
    last_count_next = last_count;
    left_hold_next  = left_dec;
    right_hold_next = right_dec;
    if (diff[CountW-1]) begin
      last_count_next = encoder_count;
      left_hold_next  = period;
    end else if (diff != '0) begin
      last_count_next = encoder_count;
      right_hold_next = period;
    end
  end

  assign flux_reference_next = reference_taken ? flux_reference : flux_z;
  assign delta = $signed({flux_reference_next[FluxW-1], flux_reference_next})
               - $signed({flux_z[FluxW-1], flux_z});
  assign delta_abs = delta[FluxW] ? -delta : delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count      <= '0;
      left_hold       <= '0;
      right_hold      <= '0;
      flux_reference  <= '0;
      reference_taken <= 1'b0;
    end else if (accept) begin
      last_count      <= last_count_next;
      left_hold       <= left_hold_next;
      right_hold      <= right_hold_next;
      flux_reference  <= flux_reference_next;
      reference_taken <= 1'b1;
    end
  end

  assign result.turned_left  = left_hold_next != '0;
  assign result.turned_right = right_hold_next != '0;
  assign result.pressed_down = delta_abs >= {1'b0, cfg.press_threshold};

endmodule

// File: sv/jfbq_obuf.sv
module jfbq_obuf
  import jfbq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    room,
  output logic    head_valid,
  input  logic    pop_ready,
  output result_t head
);

  result_t skid;
  logic    skid_valid;
  logic    pop;

  assign pop  = head_valid && pop_ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      head       <= skid;
      skid       <= din;
      skid_valid <= push;
    end else if (pop) begin
      head       <= din;
      head_valid <= push;
    end else if (push && !head_valid) begin
      head       <= din;
      head_valid <= 1'b1;
    end else if (push) begin
      skid       <= din;
      skid_valid <= 1'b1;
    end
  end

endmodule

// File: sv/jogwheel_and_flux_button_qualifier.sv
// Jog wheel and flux button qualifier.
// Input stream: one tick sample per item (encoder count, z flux, menu bit).
// Output stream: one result item per input item (left, right, pressed flags).
// Configuration: APB port, hold period for game and menu and press threshold,
// which the user must write only while the block is idle; the block itself
// does not enforce this. Reads return the register value.
// Throughput: one item per cycle while s_tready is high; the encoder difference,
// hold counters and flux compare all resolve combinationally from stored state.
// A result register plus one skid entry follow the logic, so an item is still
// taken while one result waits; s_tready drops only once both are full, and
// rises again the cycle after the receiver takes a result.
// Reset: synchronous, active high. Clears the stored count, both hold counters
// and the flux reference, restores register defaults and empties the output.
// The first sample after reset sets the flux reference.
module jogwheel_and_flux_button_qualifier
  import jfbq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [15:0] encoder_count, [27:16] flux_z, [28] menu_active, rest zero
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] turned_left, [1] turned_right, [2] pressed_down, rest zero
  output logic [OutDataW-1:0] m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg;
  result_t result;
  result_t head;
  logic    accept;

  assign accept = s_tvalid && s_tready;

  jfbq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jfbq_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .encoder_count (s_tdata[15:0]),
    .flux_z        (s_tdata[27:16]),
    .menu_active   (s_tdata[28]),
    .result        (result)
  );

  jfbq_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .din        (result),
    .room       (s_tready),
    .head_valid (m_tvalid),
    .pop_ready  (m_tready),
    .head       (head)
  );

  assign m_tdata = {5'd0, head.pressed_down, head.turned_right, head.turned_left};

endmodule

// File: sv/jfbq_checker.sv
`include "jogwheel_and_flux_button_qualifier_assert.svh"

module jfbq_checker
  import jfbq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  `JFBQ_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> !m_tvalid)
  `JFBQ_ASSERT(a_stall_holds, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `JFBQ_ASSERT(a_backpressure_needs_result, clk, rst, !s_tready |-> m_tvalid)
  `JFBQ_ASSERT(a_accept_gives_result, clk, rst, s_tvalid && s_tready |=> m_tvalid)
  `JFBQ_ASSERT(a_full_frees_after_take, clk, rst, !s_tready && m_tready |=> s_tready)

endmodule

bind jogwheel_and_flux_button_qualifier jfbq_checker u_jfbq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
